@@ rtl/wcs_pkg.sv @@
`default_nettype none
package wcs_pkg;

    localparam int DEF_CHANNELS = 16;
    localparam int DEF_WINDOWS  = 3;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 20;
    localparam int SUM_W   = 48;
    localparam int TOTAL_W = 48;
    localparam int INCR_W  = 47;
    localparam int MASK_W  = 16;
    localparam int CFG_IW  = 3;

    localparam logic [CFG_IW-1:0] REG_CHANNEL_EN = 3'd0;
    localparam logic [CFG_IW-1:0] REG_INCR_EN    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_MAX_EN     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_MIN_EN     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_AVG_EN     = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [3:0]                channel;
        logic [1:0]                window;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      sample_good;
        logic signed [TOTAL_W-1:0] total_reading;
    } t_in_item;

    typedef struct packed {
        logic [3:0]                out_channel;
        logic [1:0]                out_window;
        logic signed [VALUE_W-1:0] max_value;
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] average_value;
        logic [INCR_W-1:0]         increment;
        logic [COUNT_W-1:0]        sample_count;
        logic                      max_present;
        logic                      min_present;
        logic                      average_present;
        logic                      increment_present;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_v;
        logic signed [VALUE_W-1:0] max_v;
        logic signed [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0]        count;
        logic signed [TOTAL_W-1:0] start_total;
    } t_win_entry;

endpackage
`default_nettype wire

@@ rtl/wcs_store.sv @@
`default_nettype none
module wcs_store #(
    parameter int DEPTH = wcs_pkg::DEF_CHANNELS * wcs_pkg::DEF_WINDOWS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output wcs_pkg::t_win_entry  o_rd_data,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  wcs_pkg::t_win_entry  i_wr_data
);

    wcs_pkg::t_win_entry r_mem [DEPTH];
    wcs_pkg::t_win_entry r_rd_data;
    logic [DEPTH-1:0]    r_valid;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry never written since reset reads as all zero (an empty window).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

@@ rtl/wcs_divider.sv @@
`default_nettype none
module wcs_divider (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [wcs_pkg::SUM_W-1:0]     i_dividend,
    input  wire [wcs_pkg::COUNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [wcs_pkg::SUM_W-1:0]    o_quotient
);

    localparam int QW = wcs_pkg::SUM_W;
    localparam int DW = wcs_pkg::COUNT_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_quot;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_shift;
    logic          n_fit;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        n_shift = {r_rem[DW-1:0], r_quot[QW-1]};
        n_fit   = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_fit ? (n_shift - {1'b0, r_div}) : n_shift;
            r_quot <= {r_quot[QW-2:0], n_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule
`default_nettype wire

@@ rtl/windowed_channel_statistics_unit.sv @@
`default_nettype none
// Per-channel minimum, maximum, sum and count over several windows, kept in one
// window memory read and written back one entry at a time. An item is taken when
// start is high and busy is low. A sample does one read and one write-back per
// window; a close of an enabled channel reads and clears its window, then waits
// on the 48-step bit-serial divider that forms the average before its result is
// strobed. A close of a disabled channel only clears its window, and an item that
// is ignored leaves busy low. A result word is shown on o_result for one cycle
// with o_strobe high and cannot be held off by the receiver. Window and
// configuration state comes out of reset cleared, with no clearing pass.
module windowed_channel_statistics_unit #(
    parameter int CHANNELS = wcs_pkg::DEF_CHANNELS,
    parameter int WINDOWS  = wcs_pkg::DEF_WINDOWS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wcs_pkg::t_in_item              i_item,
    output logic                           o_strobe,
    output wcs_pkg::t_out_item             o_result,
    input  wire                            i_cfg_we,
    input  wire [wcs_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire [wcs_pkg::MASK_W-1:0]      i_cfg_data
);

    localparam int DEPTH = CHANNELS * WINDOWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VW    = wcs_pkg::VALUE_W;
    localparam int SW    = wcs_pkg::SUM_W;
    localparam int TW    = wcs_pkg::TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_MOD  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    t_state r_state;
    wcs_pkg::t_in_item r_item;
    wcs_pkg::t_win_entry r_ent;
    logic [WW-1:0] r_win;
    logic signed [TW-1:0] r_end;
    logic r_neg;

    logic [wcs_pkg::MASK_W-1:0] r_chan_en, r_incr_en, r_max_en, r_min_en, r_avg_en;
    logic signed [TW-1:0] r_latest [CHANNELS];

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    wcs_pkg::t_win_entry rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    wcs_pkg::t_win_entry wr_data;

    logic                div_start;
    logic                div_done;
    logic [SW-1:0]       div_quot;

    logic accept, ch_ok, take;
    logic signed [SW:0] upd_sum;
    logic signed [TW-1:0] latest_rd;
    wcs_pkg::t_win_entry upd;
    logic [VW-1:0] n_avg;
    logic [TW:0] inc_diff;
    wcs_pkg::t_out_item n_result;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign ch_ok  = (32'(i_item.channel) < CHANNELS);
    assign latest_rd = r_latest[CHW'(r_item.channel)];

    always_comb begin
        take = 1'b0;
        if (ch_ok) begin
            if (i_item.operation == wcs_pkg::OP_SAMPLE) begin
                take = r_chan_en[i_item.channel] && i_item.sample_good;
            end else begin
                take = (32'(i_item.window) < WINDOWS);
            end
        end
    end

    // Read port: first window (sample) or the closed window on accept, later windows from the read state.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            rd_en = accept && take;
            if (i_item.operation == wcs_pkg::OP_SAMPLE) begin
                rd_addr = AW'(32'(i_item.channel) * WINDOWS);
            end else begin
                rd_addr = AW'(32'(i_item.channel) * WINDOWS + 32'(i_item.window));
            end
        end else if (r_state == S_RD) begin
            rd_en   = 1'b1;
            rd_addr = AW'(32'(r_item.channel) * WINDOWS + 32'(r_win));
        end
    end

    always_comb begin
        upd_sum = {rd_data.sum[SW-1], rd_data.sum}
                + {{(SW + 1 - VW){r_item.sample_value[VW-1]}}, r_item.sample_value};
        upd = rd_data;
        if (rd_data.count == '0 || r_item.sample_value < rd_data.min_v) begin
            upd.min_v = r_item.sample_value;
        end
        if (rd_data.max_v < r_item.sample_value) begin
            upd.max_v = r_item.sample_value;
        end
        if (upd_sum[SW] != upd_sum[SW-1]) begin
            upd.sum = upd_sum[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end else begin
            upd.sum = upd_sum[SW-1:0];
        end
        if (rd_data.count != '1) begin
            upd.count = rd_data.count + 1'b1;
        end
    end

    always_comb begin
        wr_en   = (r_state == S_MOD);
        wr_addr = AW'(32'(r_item.channel) * WINDOWS + 32'(r_win));
        if (r_item.operation == wcs_pkg::OP_SAMPLE) begin
            wr_data = upd;
        end else begin
            wr_data             = '0;
            wr_data.start_total = latest_rd;
        end
    end

    assign div_start = (r_state == S_MOD) && (r_item.operation == wcs_pkg::OP_CLOSE)
                     && r_chan_en[r_item.channel];

    // Average: clamp the magnitude quotient to the signed value range, then sign it.
    always_comb begin
        if (r_ent.count == '0) begin
            n_avg = '0;
        end else if (r_neg) begin
            if (div_quot > SW'({1'b1, {(VW - 1){1'b0}}})) begin
                n_avg = {1'b1, {(VW - 1){1'b0}}};
            end else begin
                n_avg = -div_quot[VW-1:0];
            end
        end else if (div_quot > SW'({1'b0, {(VW - 1){1'b1}}})) begin
            n_avg = {1'b0, {(VW - 1){1'b1}}};
        end else begin
            n_avg = div_quot[VW-1:0];
        end
    end

    always_comb begin
        inc_diff = {r_end[TW-1], r_end} - {r_ent.start_total[TW-1], r_ent.start_total};
        n_result                   = '0;
        n_result.out_channel       = r_item.channel;
        n_result.out_window        = r_item.window;
        n_result.sample_count      = r_ent.count;
        n_result.max_present       = r_max_en[r_item.channel];
        n_result.min_present       = r_min_en[r_item.channel];
        n_result.average_present   = r_avg_en[r_item.channel];
        n_result.increment_present = r_incr_en[r_item.channel];
        if (r_max_en[r_item.channel]) begin
            n_result.max_value = r_ent.max_v;
        end
        if (r_min_en[r_item.channel] && r_ent.count != '0) begin
            n_result.min_value = r_ent.min_v;
        end
        if (r_avg_en[r_item.channel]) begin
            n_result.average_value = n_avg;
        end
        if (r_incr_en[r_item.channel] && !r_ent.start_total[TW-1]
                && (r_end > r_ent.start_total)) begin
            n_result.increment = inc_diff[wcs_pkg::INCR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == S_MOD) begin
            r_ent <= rd_data;
            r_end <= latest_rd;
            r_neg <= rd_data.sum[SW-1];
        end
        if (r_state == S_DIV && div_done) begin
            o_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win     <= '0;
            o_strobe  <= 1'b0;
            r_chan_en <= '0;
            r_incr_en <= '0;
            r_max_en  <= '0;
            r_min_en  <= '0;
            r_avg_en  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_latest[i] <= '0;
            end
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wcs_pkg::REG_CHANNEL_EN: r_chan_en <= i_cfg_data;
                    wcs_pkg::REG_INCR_EN:    r_incr_en <= i_cfg_data;
                    wcs_pkg::REG_MAX_EN:     r_max_en  <= i_cfg_data;
                    wcs_pkg::REG_MIN_EN:     r_min_en  <= i_cfg_data;
                    wcs_pkg::REG_AVG_EN:     r_avg_en  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && take) begin
                        r_state <= S_MOD;
                        r_win   <= (i_item.operation == wcs_pkg::OP_SAMPLE)
                                 ? '0 : WW'(i_item.window);
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_item.operation == wcs_pkg::OP_SAMPLE) begin
                        if (32'(r_win) == WINDOWS - 1) begin
                            r_latest[CHW'(r_item.channel)] <= r_item.total_reading;
                            r_state <= S_IDLE;
                        end else begin
                            r_win   <= r_win + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        o_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    wcs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    wcs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd_data.sum[SW-1] ? SW'(-rd_data.sum) : SW'(rd_data.sum)),
        .i_divisor  (rd_data.count),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

endmodule
`default_nettype wire

@@ tb/sv/wcs_checker.sv @@
`timescale 1ns / 1ps

module wcs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  wcs_pkg::t_in_item             i_item,
    input  logic                          o_strobe,
    input  wcs_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [wcs_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [wcs_pkg::MASK_W-1:0]    i_cfg_data,
    output int                            fail_count,
    output int                            pending_count
);
    localparam int NCH  = 16;
    localparam int NWIN = 3;
    localparam int VW   = wcs_pkg::VALUE_W;
    localparam int SW   = wcs_pkg::SUM_W;
    localparam int CW   = wcs_pkg::COUNT_W;
    localparam int TW   = wcs_pkg::TOTAL_W;
    localparam int MW   = wcs_pkg::MASK_W;
    localparam longint SUM_HI = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint VAL_HI = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_LO = -VAL_HI - 1;

    logic signed [VW-1:0] win_min [NCH*NWIN];
    logic signed [VW-1:0] win_max [NCH*NWIN];
    logic signed [SW-1:0] win_sum [NCH*NWIN];
    logic [CW-1:0]        win_cnt [NCH*NWIN];
    logic signed [TW-1:0] win_start [NCH*NWIN];
    logic signed [TW-1:0] last_total [NCH];
    logic [MW-1:0] chan_en, incr_en, max_en, min_en, avg_en;

    wcs_pkg::t_out_item report_q [$];
    int                 errors;

    task automatic clear_window(input int idx, input int ch);
        win_min[idx] = '0;
        win_max[idx] = '0;
        win_sum[idx] = '0;
        win_cnt[idx] = '0;
        win_start[idx] = last_total[ch];
    endtask

    task automatic predict_word(input wcs_pkg::t_in_item it);
        int ch;
        int idx;
        logic signed [VW-1:0] v;
        longint s;
        longint avg;
        longint st;
        longint fin;
        longint d;
        wcs_pkg::t_out_item r;
        ch = it.channel;
        v = it.sample_value;
        if (it.operation == wcs_pkg::OP_SAMPLE) begin
            if (!chan_en[ch] || !it.sample_good) return;
            for (int w = 0; w < NWIN; w++) begin
                idx = ch * NWIN + w;
                if (win_cnt[idx] == 0 || v < win_min[idx]) win_min[idx] = v;
                if (win_max[idx] < v) win_max[idx] = v;
                s = longint'(win_sum[idx]) + longint'(v);
                if (s > SUM_HI) s = SUM_HI;
                if (s < SUM_LO) s = SUM_LO;
                win_sum[idx] = s[SW-1:0];
                if (win_cnt[idx] != {CW{1'b1}}) win_cnt[idx] = win_cnt[idx] + 1'b1;
            end
            last_total[ch] = it.total_reading;
            return;
        end
        if (it.window >= NWIN) return;
        idx = ch * NWIN + it.window;
        if (!chan_en[ch]) begin
            clear_window(idx, ch);
            return;
        end
        avg = 0;
        if (win_cnt[idx] != 0) begin
            avg = longint'(win_sum[idx]) / longint'(win_cnt[idx]);
            if (avg > VAL_HI) avg = VAL_HI;
            if (avg < VAL_LO) avg = VAL_LO;
        end
        st = longint'(win_start[idx]);
        fin = longint'(last_total[ch]);
        d = fin - st;
        r = '0;
        r.out_channel = it.channel;
        r.out_window = it.window;
        r.max_present = max_en[ch];
        r.min_present = min_en[ch];
        r.average_present = avg_en[ch];
        r.increment_present = incr_en[ch];
        r.sample_count = win_cnt[idx];
        if (max_en[ch]) r.max_value = win_max[idx];
        if (min_en[ch] && win_cnt[idx] != 0) r.min_value = win_min[idx];
        if (avg_en[ch]) r.average_value = avg[VW-1:0];
        if (incr_en[ch] && st >= 0 && fin > st) r.increment = d[wcs_pkg::INCR_W-1:0];
        report_q.push_back(r);
        clear_window(idx, ch);
    endtask

    task automatic check_word(input wcs_pkg::t_out_item got);
        wcs_pkg::t_out_item exp;
        if (report_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word: %h", got);
            return;
        end
        exp = report_q.pop_front();
        if (got.out_channel !== exp.out_channel || got.out_window !== exp.out_window
            || got.max_value !== exp.max_value || got.min_value !== exp.min_value
            || got.average_value !== exp.average_value || got.increment !== exp.increment
            || got.sample_count !== exp.sample_count || got.max_present !== exp.max_present
            || got.min_present !== exp.min_present
            || got.average_present !== exp.average_present
            || got.increment_present !== exp.increment_present) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch ch %0d win %0d", exp.out_channel, exp.out_window);
                $display("  expected max %0d min %0d avg %0d inc %0d cnt %0d flags %b%b%b%b",
                         exp.max_value, exp.min_value, exp.average_value, exp.increment,
                         exp.sample_count, exp.max_present, exp.min_present,
                         exp.average_present, exp.increment_present);
                $display("  actual ch %0d win %0d max %0d min %0d avg %0d inc %0d",
                         got.out_channel, got.out_window, got.max_value, got.min_value,
                         got.average_value, got.increment);
                $display("  actual cnt %0d flags %b%b%b%b",
                         got.sample_count, got.max_present, got.min_present,
                         got.average_present, got.increment_present);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH*NWIN; i++) begin
                win_min[i] = '0;
                win_max[i] = '0;
                win_sum[i] = '0;
                win_cnt[i] = '0;
                win_start[i] = '0;
            end
            for (int c = 0; c < NCH; c++) last_total[c] = '0;
            chan_en = '0;
            incr_en = '0;
            max_en = '0;
            min_en = '0;
            avg_en = '0;
            report_q.delete();
            errors = 0;
        end else begin
            if (o_strobe) check_word(o_result);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wcs_pkg::REG_CHANNEL_EN: chan_en = i_cfg_data;
                    wcs_pkg::REG_INCR_EN:    incr_en = i_cfg_data;
                    wcs_pkg::REG_MAX_EN:     max_en = i_cfg_data;
                    wcs_pkg::REG_MIN_EN:     min_en = i_cfg_data;
                    wcs_pkg::REG_AVG_EN:     avg_en = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) predict_word(i_item);
        end
        fail_count <= errors;
        pending_count <= report_q.size();
    end
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int VW = wcs_pkg::VALUE_W;
    localparam int TW = wcs_pkg::TOTAL_W;
    localparam int MW = wcs_pkg::MASK_W;
    localparam int IW = wcs_pkg::CFG_IW;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    wcs_pkg::t_in_item   i_item;
    logic                o_strobe;
    wcs_pkg::t_out_item  o_result;
    logic                i_cfg_we;
    logic [IW-1:0]       i_cfg_index;
    logic [MW-1:0]       i_cfg_data;
    int                  fail_count;
    int                  pending_count;
    int                  cycles;
    bit                  quiet;
    logic signed [TW-1:0] meter [16];

    windowed_channel_statistics_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    wcs_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("windowed_channel_statistics_unit test failed");
            $finish;
        end
    end

    // Keeps start high across back-to-back words; drops it only for an idle burst.
    task automatic send_word(input wcs_pkg::t_in_item it);
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_masks(input logic [MW-1:0] ce, input logic [MW-1:0] ie,
                               input logic [MW-1:0] xe, input logic [MW-1:0] ne,
                               input logic [MW-1:0] ae);
        logic [MW-1:0] vals [5];
        logic [IW-1:0] regs [5];
        vals = '{ce, ie, xe, ne, ae};
        regs = '{wcs_pkg::REG_CHANNEL_EN, wcs_pkg::REG_INCR_EN, wcs_pkg::REG_MAX_EN,
                 wcs_pkg::REG_MIN_EN, wcs_pkg::REG_AVG_EN};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic wcs_pkg::t_in_item word_of(input logic op, input int ch, input int win,
                                                  input logic signed [VW-1:0] v,
                                                  input logic good,
                                                  input logic signed [TW-1:0] tot);
        wcs_pkg::t_in_item it;
        it.operation = op;
        it.channel = ch[3:0];
        it.window = win[1:0];
        it.sample_value = v;
        it.sample_good = good;
        it.total_reading = tot;
        return it;
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sd1;
            4, 5: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic wcs_pkg::t_in_item random_word();
        int ch;
        int win;
        logic signed [TW-1:0] tot;
        logic [63:0] raw;
        ch = $urandom_range(0, 15);
        win = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
        raw = {$urandom, $urandom};
        // Totals mostly climb per channel; now and then unknown or arbitrary.
        case ($urandom_range(0, 9))
            0: tot = -$signed({16'h0, $urandom}) - 1;
            1: tot = raw[TW-1:0];
            default: begin
                meter[ch] = meter[ch] + $urandom_range(0, 100000);
                tot = meter[ch];
            end
        endcase
        return word_of($urandom_range(0, 3) == 0 ? wcs_pkg::OP_CLOSE : wcs_pkg::OP_SAMPLE,
                       ch, win, pick_value(), $urandom_range(0, 9) != 0, tot);
    endfunction

    initial begin
        cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int c = 0; c < 16; c++) meter[c] = $urandom_range(0, 1000);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: everything reported, channel 0 disabled.
        write_masks(16'hfffe, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_word(word_of(wcs_pkg::OP_CLOSE, 1, 0, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 1, 0, 32'sh7fff_ffff, 1'b1,
                          48'sh7fff_ffff_ffff));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 1, 0, 32'sh8000_0000, 1'b1,
                          48'sh7fff_ffff_ffff));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 1, 0, 5, 1'b0, 48'sh8000_0000_0000));
        send_word(word_of(wcs_pkg::OP_CLOSE, 1, 0, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_CLOSE, 1, 1, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 1, 0, -7, 1'b1, 100));
        send_word(word_of(wcs_pkg::OP_CLOSE, 1, 2, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_CLOSE, 1, 0, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_CLOSE, 1, 3, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 0, 0, 9, 1'b1, 55));
        send_word(word_of(wcs_pkg::OP_CLOSE, 0, 1, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 15, 0, -32'sd1, 1'b1, -1));
        send_word(word_of(wcs_pkg::OP_CLOSE, 15, 0, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 15, 0, 3, 1'b1, 48'sh0000_0001_0000));
        send_word(word_of(wcs_pkg::OP_SAMPLE, 15, 0, 4, 1'b1, 48'sh0000_0002_0000));
        send_word(word_of(wcs_pkg::OP_CLOSE, 15, 2, 0, 1'b1, 0));
        send_word(word_of(wcs_pkg::OP_CLOSE, 15, 1, 0, 1'b1, 0));
        settle();

        // Random phases under different mask settings, extremes first.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_masks(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
                1: write_masks(16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
                2: write_masks(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: write_masks(16'($urandom) | 16'h00ff, 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            if (phase == 5) quiet = 1'b1;
            repeat (phase == 1 ? 100 : 360) send_word(random_word());
            settle();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("windowed_channel_statistics_unit test passed");
        end else begin
            $display("windowed_channel_statistics_unit test failed");
        end
        $finish;
    end
endmodule
